/* design/pwt_pkg.sv */
// Shared constants, codes and types of the Prewitt edge threshold core.
// Used by every module of the block but pwt_ram; depends on nothing else.
`timescale 1ns / 1ps

package pwt_pkg;

   localparam int MAX_WIDTH  = 512;
   localparam int MAX_HEIGHT = 512;
   localparam int DIM_MIN    = 3;

   localparam int SIZE_W  = 10;                                  // size register width
   localparam int PIX_W   = 8;
   localparam int PIX_MAX = (1 << PIX_W) - 1;
   localparam int WDIM_W  = $clog2(MAX_WIDTH + 1);               // holds a clamped width
   localparam int HDIM_W  = $clog2(MAX_HEIGHT + 1);              // holds a clamped height
   localparam int COL_W   = $clog2(MAX_WIDTH);
   localparam int ROW_W   = $clog2(MAX_HEIGHT);
   localparam int IDX_W   = COL_W + ROW_W;
   localparam int TOTAL_W = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
   localparam int PROD_W  = WDIM_W + HDIM_W;
   localparam int SUM_W   = $clog2(3 * PIX_MAX + 1);             // one column of three pixels
   localparam int CNT_W   = $clog2(IDX_W + 1);
   localparam int G20_W   = PIX_W + 5;                           // gradient times twenty
   localparam int CSR_IDX_W = 1;

   localparam logic [CSR_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'd0;
   localparam logic [CSR_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'd1;

   localparam logic CMD_LOAD = 1'b0;
   localparam logic CMD_READ = 1'b1;

   localparam logic STATUS_VALID   = 1'b0;
   localparam logic STATUS_PENDING = 1'b1;

   localparam logic [PIX_W-1:0] EDGE_ON  = 8'd0;
   localparam logic [PIX_W-1:0] EDGE_OFF = 8'd255;

   typedef enum logic [1:0] {
      SEQ_IDLE,
      SEQ_TOTAL,
      SEQ_CHECK,
      SEQ_DIVIDE
   } seq_state_type;

   typedef struct packed {
      logic [WDIM_W-1:0]  width;
      logic [HDIM_W-1:0]  height;
      logic [TOTAL_W-1:0] total;
   } size_type;

   // Read position after a size change: clear it, or load row and column.
   typedef struct packed {
      logic             load;
      logic             clear;
      logic [ROW_W-1:0] row;
      logic [COL_W-1:0] col;
   } rescale_type;

   typedef struct packed {
      logic             is_read;
      logic [PIX_W-1:0] pix;
      logic [COL_W-1:0] col;
      logic [IDX_W-1:0] grad_addr;
      logic             interior;
      logic             frame_start;
      logic             loaded;
      logic             border;
      logic             last;
   } stage_type;

endpackage

/* design/pwt_ram.sv */
// Generic single-port-write, single-port-read memory with registered read data.
// Stands alone; used by pwt_grad for the line store and the gradient store.
`timescale 1ns / 1ps

module pwt_ram #(
   parameter int DEPTH = 512,
   parameter int WIDTH = 8,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* design/pwt_size.sv */
// Size registers, frame total and a rescaler that divides the read index by the width.
// Depends on pwt_pkg; a size write reruns the total, then rescales or clears the read index.
`timescale 1ns / 1ps

module pwt_size (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [pwt_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [pwt_pkg::SIZE_W-1:0]    csr_data,
   input  logic [pwt_pkg::IDX_W-1:0]     read_index,
   output pwt_pkg::size_type             size,
   output pwt_pkg::rescale_type          rescale,
   output logic                          busy
);

   pwt_pkg::seq_state_type state_ff, state_in;

   logic [pwt_pkg::WDIM_W-1:0]  width_ff, width_in;
   logic [pwt_pkg::HDIM_W-1:0]  height_ff, height_in;
   logic [pwt_pkg::TOTAL_W-1:0] total_ff;
   logic [pwt_pkg::IDX_W-1:0]   div_num_ff;
   logic [pwt_pkg::IDX_W-1:0]   div_quo_ff;
   logic [pwt_pkg::WDIM_W-1:0]  div_rem_ff;
   logic [pwt_pkg::CNT_W-1:0]   div_cnt_ff;

   logic                        csr_write;
   logic                        over_range;
   logic [pwt_pkg::PROD_W-1:0]  product;
   logic [pwt_pkg::WDIM_W:0]    trial;
   logic                        trial_fits;

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid;

   // Sizes are clamped once, when they are written.
   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_write) begin
         unique case (csr_index)
            pwt_pkg::REG_IMAGE_WIDTH: begin
               if (int'(csr_data) < pwt_pkg::DIM_MIN) begin
                  width_in = pwt_pkg::WDIM_W'(pwt_pkg::DIM_MIN);
               end else if (int'(csr_data) > pwt_pkg::MAX_WIDTH) begin
                  width_in = pwt_pkg::WDIM_W'(pwt_pkg::MAX_WIDTH);
               end else begin
                  width_in = pwt_pkg::WDIM_W'(csr_data);
               end
            end
            pwt_pkg::REG_IMAGE_HEIGHT: begin
               if (int'(csr_data) < pwt_pkg::DIM_MIN) begin
                  height_in = pwt_pkg::HDIM_W'(pwt_pkg::DIM_MIN);
               end else if (int'(csr_data) > pwt_pkg::MAX_HEIGHT) begin
                  height_in = pwt_pkg::HDIM_W'(pwt_pkg::MAX_HEIGHT);
               end else begin
                  height_in = pwt_pkg::HDIM_W'(csr_data);
               end
            end
            default: begin
            end
         endcase
      end
   end

   assign product    = pwt_pkg::PROD_W'(width_ff) * pwt_pkg::PROD_W'(height_ff);
   assign over_range = pwt_pkg::TOTAL_W'(read_index) >= total_ff;
   assign trial      = {div_rem_ff, div_num_ff[pwt_pkg::IDX_W-1]};
   assign trial_fits = trial >= {1'b0, width_ff};

   always_comb begin
      state_in = state_ff;
      if (csr_write) begin
         state_in = pwt_pkg::SEQ_TOTAL;
      end else begin
         unique case (state_ff)
            pwt_pkg::SEQ_IDLE:  state_in = pwt_pkg::SEQ_IDLE;
            pwt_pkg::SEQ_TOTAL: state_in = pwt_pkg::SEQ_CHECK;
            pwt_pkg::SEQ_CHECK: begin
               state_in = over_range ? pwt_pkg::SEQ_IDLE : pwt_pkg::SEQ_DIVIDE;
            end
            pwt_pkg::SEQ_DIVIDE: begin
               if (div_cnt_ff == '0) begin
                  state_in = pwt_pkg::SEQ_IDLE;
               end
            end
            default: state_in = pwt_pkg::SEQ_IDLE;
         endcase
      end
   end

   always_comb begin
      rescale = '0;
      busy    = 1'b1;
      unique case (state_ff)
         pwt_pkg::SEQ_IDLE: begin
            busy = 1'b0;
         end
         pwt_pkg::SEQ_TOTAL: begin
         end
         pwt_pkg::SEQ_CHECK: begin
            rescale.load  = over_range;
            rescale.clear = over_range;
         end
         pwt_pkg::SEQ_DIVIDE: begin
            rescale.load = (div_cnt_ff == '0);
            rescale.row  = div_quo_ff[pwt_pkg::ROW_W-1:0];
            rescale.col  = div_rem_ff[pwt_pkg::COL_W-1:0];
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= pwt_pkg::SEQ_IDLE;
         width_ff  <= pwt_pkg::WDIM_W'(pwt_pkg::MAX_WIDTH);
         height_ff <= pwt_pkg::HDIM_W'(pwt_pkg::MAX_HEIGHT);
         total_ff  <= pwt_pkg::TOTAL_W'(pwt_pkg::MAX_WIDTH * pwt_pkg::MAX_HEIGHT);
      end else begin
         state_ff  <= state_in;
         width_ff  <= width_in;
         height_ff <= height_in;
         if (state_ff == pwt_pkg::SEQ_TOTAL) begin
            total_ff <= pwt_pkg::TOTAL_W'(product);
         end
      end
   end

   // Restoring division, one quotient bit per cycle: row = index / width, col = remainder.
   always_ff @(posedge clock) begin
      if (state_ff == pwt_pkg::SEQ_CHECK) begin
         div_num_ff <= read_index;
         div_quo_ff <= '0;
         div_rem_ff <= '0;
         div_cnt_ff <= pwt_pkg::CNT_W'(pwt_pkg::IDX_W);
      end else if (state_ff == pwt_pkg::SEQ_DIVIDE && div_cnt_ff != '0) begin
         div_num_ff <= {div_num_ff[pwt_pkg::IDX_W-2:0], 1'b0};
         div_quo_ff <= {div_quo_ff[pwt_pkg::IDX_W-2:0], trial_fits};
         div_rem_ff <= trial_fits ? pwt_pkg::WDIM_W'(trial - {1'b0, width_ff})
                                  : pwt_pkg::WDIM_W'(trial);
         div_cnt_ff <= div_cnt_ff - 1'b1;
      end
   end

   assign size.width  = width_ff;
   assign size.height = height_ff;
   assign size.total  = total_ff;

endmodule

/* design/pwt_ctrl.sv */
// Input stage: load and read position counters, frame state and the input register.
// Depends on pwt_pkg; feeds the memory addresses of pwt_grad and the stage word to the top.
`timescale 1ns / 1ps

module pwt_ctrl (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       accept,
   input  logic                       req_command,
   input  logic [pwt_pkg::PIX_W-1:0]  req_pixel,
   input  pwt_pkg::size_type          size,
   input  pwt_pkg::rescale_type       rescale,
   output logic [pwt_pkg::COL_W-1:0]  row_addr,
   output logic [pwt_pkg::IDX_W-1:0]  grad_rd_addr,
   output logic [pwt_pkg::IDX_W-1:0]  read_index,
   output pwt_pkg::stage_type         stage
);

   logic [pwt_pkg::COL_W-1:0]  load_col_ff;
   logic [pwt_pkg::ROW_W-1:0]  load_row_ff;
   logic                       frame_loaded_ff;
   logic [pwt_pkg::IDX_W-1:0]  read_index_ff;
   logic [pwt_pkg::ROW_W-1:0]  read_row_ff;
   logic [pwt_pkg::COL_W-1:0]  read_col_ff;
   pwt_pkg::stage_type         stage_ff;

   logic                       col_wrap;
   logic [pwt_pkg::HDIM_W-1:0] row_tmp;
   logic [pwt_pkg::COL_W-1:0]  c_eff;
   logic [pwt_pkg::ROW_W-1:0]  r_eff;
   logic                       c_last;
   logic                       r_last;
   logic                       frame_start;
   logic                       interior;
   logic                       read_border;
   logic                       read_last;
   logic                       do_load;
   logic                       do_read;

   // A column or row left past a smaller size wraps before it is used.
   always_comb begin
      col_wrap = pwt_pkg::WDIM_W'(load_col_ff) >= size.width;
      row_tmp  = pwt_pkg::HDIM_W'(load_row_ff) + (col_wrap ? 1'b1 : 1'b0);
      c_eff    = col_wrap ? '0 : load_col_ff;
      r_eff    = pwt_pkg::ROW_W'(row_tmp);
      if (row_tmp >= size.height) begin
         c_eff = '0;
         r_eff = '0;
      end
   end

   assign c_last      = pwt_pkg::WDIM_W'(c_eff) + 1'b1 >= size.width;
   assign r_last      = pwt_pkg::HDIM_W'(r_eff) + 1'b1 >= size.height;
   assign frame_start = (r_eff == '0) && (c_eff == '0);
   assign interior    = (r_eff >= pwt_pkg::ROW_W'(2)) && (c_eff >= pwt_pkg::COL_W'(2));

   assign read_border = (read_row_ff == '0) || (read_col_ff == '0)
                     || (pwt_pkg::HDIM_W'(read_row_ff) + 1'b1 >= size.height)
                     || (pwt_pkg::WDIM_W'(read_col_ff) + 1'b1 >= size.width);
   assign read_last   = pwt_pkg::TOTAL_W'(read_index_ff) + 1'b1 >= size.total;

   assign do_load = accept && (req_command == pwt_pkg::CMD_LOAD);
   assign do_read = accept && (req_command == pwt_pkg::CMD_READ) && frame_loaded_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         load_col_ff     <= '0;
         load_row_ff     <= '0;
         frame_loaded_ff <= 1'b0;
         read_index_ff   <= '0;
         read_row_ff     <= '0;
         read_col_ff     <= '0;
      end else begin
         if (do_load) begin
            if (frame_start) begin
               frame_loaded_ff <= 1'b0;
               read_index_ff   <= '0;
               read_row_ff     <= '0;
               read_col_ff     <= '0;
            end
            if (c_last && r_last) begin
               frame_loaded_ff <= 1'b1;
               load_col_ff     <= '0;
               load_row_ff     <= '0;
            end else if (c_last) begin
               load_col_ff <= '0;
               load_row_ff <= r_eff + 1'b1;
            end else begin
               load_col_ff <= c_eff + 1'b1;
               load_row_ff <= r_eff;
            end
         end
         if (do_read) begin
            if (read_last) begin
               read_index_ff <= '0;
               read_row_ff   <= '0;
               read_col_ff   <= '0;
            end else begin
               read_index_ff <= read_index_ff + 1'b1;
               if (pwt_pkg::WDIM_W'(read_col_ff) + 1'b1 >= size.width) begin
                  read_col_ff <= '0;
                  read_row_ff <= read_row_ff + 1'b1;
               end else begin
                  read_col_ff <= read_col_ff + 1'b1;
               end
            end
         end
         // Only arrives while no word is taken in.
         if (rescale.load) begin
            if (rescale.clear) begin
               read_index_ff <= '0;
               read_row_ff   <= '0;
               read_col_ff   <= '0;
            end else begin
               read_row_ff <= rescale.row;
               read_col_ff <= rescale.col;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         stage_ff.is_read     <= (req_command == pwt_pkg::CMD_READ);
         stage_ff.pix         <= req_pixel;
         stage_ff.col         <= c_eff;
         stage_ff.grad_addr   <= {r_eff - 1'b1, c_eff - 1'b1};
         stage_ff.interior    <= interior;
         stage_ff.frame_start <= frame_start;
         stage_ff.loaded      <= frame_loaded_ff;
         stage_ff.border      <= read_border;
         stage_ff.last        <= read_last;
      end
   end

   assign row_addr     = c_eff;
   assign grad_rd_addr = {read_row_ff, read_col_ff};
   assign read_index   = read_index_ff;
   assign stage        = stage_ff;

endmodule

/* design/pwt_grad.sv */
// Gradient stage: line store, column sums, Prewitt difference, running maximum
// and the gradient store. Depends on pwt_pkg and pwt_ram.
`timescale 1ns / 1ps

module pwt_grad (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      accept,
   input  logic [pwt_pkg::COL_W-1:0] row_addr,
   input  logic [pwt_pkg::IDX_W-1:0] grad_rd_addr,
   input  logic                      work,
   input  pwt_pkg::stage_type        stage,
   output logic [pwt_pkg::PIX_W-1:0] grad_value,
   output logic [pwt_pkg::SUM_W-1:0] running_max
);

   logic [2*pwt_pkg::PIX_W-1:0] line_rd;
   logic [2*pwt_pkg::PIX_W-1:0] line_wr;
   logic [pwt_pkg::PIX_W-1:0]   older_pix;
   logic [pwt_pkg::PIX_W-1:0]   newer_pix;
   logic [pwt_pkg::SUM_W-1:0]   col_sum;
   logic signed [pwt_pkg::SUM_W:0] diff;
   logic [pwt_pkg::PIX_W-1:0]   diff_sat;
   logic                        grad_wr_en;

   logic [pwt_pkg::SUM_W-1:0]   sum1_ff;
   logic [pwt_pkg::SUM_W-1:0]   sum2_ff;
   logic [pwt_pkg::SUM_W-1:0]   max_ff;

   // Each line store entry keeps the two rows above, the older one in the low byte.
   assign older_pix = line_rd[pwt_pkg::PIX_W-1:0];
   assign newer_pix = line_rd[2*pwt_pkg::PIX_W-1:pwt_pkg::PIX_W];
   assign line_wr   = {stage.pix, newer_pix};

   pwt_ram #(
      .DEPTH (pwt_pkg::MAX_WIDTH),
      .WIDTH (2 * pwt_pkg::PIX_W)
   ) u_line_ram (
      .clock   (clock),
      .wr_en   (work),
      .wr_addr (stage.col),
      .wr_data (line_wr),
      .rd_en   (accept),
      .rd_addr (row_addr),
      .rd_data (line_rd)
   );

   assign col_sum = pwt_pkg::SUM_W'(older_pix) + pwt_pkg::SUM_W'(newer_pix)
                  + pwt_pkg::SUM_W'(stage.pix);
   assign diff    = $signed({1'b0, col_sum}) - $signed({1'b0, sum2_ff});

   always_comb begin
      if (diff < 0) begin
         diff_sat = '0;
      end else if (diff > $signed((pwt_pkg::SUM_W+1)'(pwt_pkg::PIX_MAX))) begin
         diff_sat = pwt_pkg::PIX_W'(pwt_pkg::PIX_MAX);
      end else begin
         diff_sat = diff[pwt_pkg::PIX_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum1_ff <= '0;
         sum2_ff <= '0;
         max_ff  <= '0;
      end else if (work) begin
         sum1_ff <= col_sum;
         sum2_ff <= sum1_ff;
         if (stage.frame_start) begin
            max_ff <= '0;
         end else if (stage.interior && (diff > $signed({1'b0, max_ff}))) begin
            max_ff <= diff[pwt_pkg::SUM_W-1:0];
         end
      end
   end

   assign grad_wr_en = work && stage.interior;

   pwt_ram #(
      .DEPTH (2 ** pwt_pkg::IDX_W),
      .WIDTH (pwt_pkg::PIX_W)
   ) u_grad_ram (
      .clock   (clock),
      .wr_en   (grad_wr_en),
      .wr_addr (stage.grad_addr),
      .wr_data (diff_sat),
      .rd_en   (accept),
      .rd_addr (grad_rd_addr),
      .rd_data (grad_value)
   );

   assign running_max = max_ff;

endmodule

/* design/prewitt_edge_threshold_core.sv */
// Horizontal Prewitt edge detector with automatic threshold. Load words (tuser 0) carry
// gray pixels of one frame in raster order; read words (tuser 1) return one result each:
// 0 where the saturated gradient exceeds floor(max/20) of the frame's largest raw sum,
// 255 elsewhere and on the border, tlast on the frame's final pixel, and tuser 1 with
// data 0 while the frame is not yet fully loaded. One word is taken per cycle while the
// result register is free or being taken and no size update runs. A read word passes
// the input register and the gradient store read before its result is registered.
// After a size register write, tready stays low while the frame total is formed and a
// one-bit-per-cycle divider maps the read position onto the new width or, past the new
// total, clears it. Depends on pwt_pkg, pwt_size, pwt_ctrl, pwt_grad and pwt_ram.
`timescale 1ns / 1ps

module prewitt_edge_threshold_core (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [7:0]                    req_tdata,   // [7:0] gray_pixel
   input  logic                          req_tuser,   // [0] command
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [7:0]                    rsp_tdata,   // [7:0] edge_value
   output logic                          rsp_tlast,   // last_pixel
   output logic                          rsp_tuser,   // [0] status
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [pwt_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [pwt_pkg::SIZE_W-1:0]    csr_data
);

   pwt_pkg::size_type          size;
   pwt_pkg::rescale_type       rescale;
   pwt_pkg::stage_type         stage;
   logic                       busy;
   logic                       advance;
   logic                       accept;
   logic                       work;
   logic [pwt_pkg::COL_W-1:0]  row_addr;
   logic [pwt_pkg::IDX_W-1:0]  grad_rd_addr;
   logic [pwt_pkg::IDX_W-1:0]  read_index;
   logic [pwt_pkg::PIX_W-1:0]  grad_value;
   logic [pwt_pkg::SUM_W-1:0]  running_max;
   logic [pwt_pkg::G20_W-1:0]  grad_x20;
   logic                       is_edge;

   logic                       s1_valid_ff;
   logic                       rsp_valid_ff;
   logic [pwt_pkg::PIX_W-1:0]  rsp_data_ff;
   logic                       rsp_last_ff;
   logic                       rsp_status_ff;

   // The whole pipe moves when the result register is empty or being taken.
   assign advance    = !rsp_valid_ff || rsp_tready;
   assign req_tready = advance && !busy;
   assign accept     = req_tvalid && req_tready;
   assign work       = advance && s1_valid_ff && !stage.is_read;

   pwt_size u_size (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .read_index (read_index),
      .size       (size),
      .rescale    (rescale),
      .busy       (busy)
   );

   pwt_ctrl u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .req_command  (req_tuser),
      .req_pixel    (req_tdata),
      .size         (size),
      .rescale      (rescale),
      .row_addr     (row_addr),
      .grad_rd_addr (grad_rd_addr),
      .read_index   (read_index),
      .stage        (stage)
   );

   pwt_grad u_grad (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .row_addr     (row_addr),
      .grad_rd_addr (grad_rd_addr),
      .work         (work),
      .stage        (stage),
      .grad_value   (grad_value),
      .running_max  (running_max)
   );

   // gradient > floor(max / 20) holds exactly when 20 * gradient > max.
   assign grad_x20 = {1'b0, grad_value, 4'b0000} + {3'b000, grad_value, 2'b00};
   assign is_edge  = !stage.border && (pwt_pkg::G20_W'(running_max) < grad_x20);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff  <= accept;
         rsp_valid_ff <= s1_valid_ff && stage.is_read;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         if (stage.loaded) begin
            rsp_data_ff   <= is_edge ? pwt_pkg::EDGE_ON : pwt_pkg::EDGE_OFF;
            rsp_last_ff   <= stage.last;
            rsp_status_ff <= pwt_pkg::STATUS_VALID;
         end else begin
            rsp_data_ff   <= pwt_pkg::EDGE_ON;
            rsp_last_ff   <= 1'b0;
            rsp_status_ff <= pwt_pkg::STATUS_PENDING;
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = rsp_status_ff;

endmodule
